FILE: rtl/indent_dedent_token_scanner_defines.svh
// Assertion macros shared by the checker of the layout token scanner.
// No dependencies; included by files that hold concurrent assertions.
`ifndef INDENT_DEDENT_TOKEN_SCANNER_DEFINES_SVH
`define INDENT_DEDENT_TOKEN_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IDTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IDTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/idts_pkg.sv
// Package of the layout token scanner: widths, character codes, token kinds
// and the command and status types between controller and datapath.
// No dependencies.
package idts_pkg;

  // Depth of the stack of open indentation widths.
  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = $clog2(STACK_DEPTH);

  // Fixed field widths.
  localparam int BYTE_W  = 8;
  localparam int WIDTH_W = 16;
  localparam int KIND_W  = 2;

  // Tabs advance the width to the next multiple of this stop.
  localparam int TAB_STOP = 8;

  // Character codes.
  localparam logic [BYTE_W-1:0] CH_EOF = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;

  typedef enum logic [KIND_W-1:0] {
    TK_NEWLINE = 2'd0,
    TK_INDENT  = 2'd1,
    TK_DEDENT  = 2'd2,
    TK_ERROR   = 2'd3
  } token_kind_e;

  // Class of an incoming byte, taking the indentation run into account.
  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_EOF    = 3'd1,
    CLS_LF     = 3'd2,
    CLS_BLANK  = 3'd3,
    CLS_SETTLE = 3'd4
  } byte_cls_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        accept;
    logic        push;
    logic        pop;
    logic        emit;
    token_kind_e kind;
    logic        last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    byte_cls_e cls;
    logic      out_free;
    logic      w_gt_top;
    logic      w_eq_top;
    logic      w_gt_second;
    logic      w_eq_second;
  } status_t;

endpackage

FILE: rtl/idts_byte_if.sv
// Input channel of the layout token scanner: one text byte per request.
// Depends on idts_pkg.
interface idts_byte_if;
  import idts_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);

endinterface

FILE: rtl/idts_token_if.sv
// Output channel of the layout token scanner: one layout token per request.
// Depends on idts_pkg.
interface idts_token_if;
  import idts_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  token_kind;
  logic               last_token;
  logic [WIDTH_W-1:0] line_width;
  logic [CNT_W-1:0]   open_levels;

  modport source (output valid, output token_kind, output last_token,
                  output line_width, output open_levels, input ready);
  modport sink   (input valid, input token_kind, input last_token,
                  input line_width, input open_levels, output ready);

endinterface

FILE: rtl/indent_dedent_token_scanner.sv
// Top level of the layout token scanner: controller plus datapath.
// Depends on idts_pkg, idts_byte_if, idts_token_if, idts_ctrl, idts_datapath.
//
//   Port     Direction  Carries
//   byte_i   sink       text_byte, one source byte per request (0 = end of input)
//   token_o  source     token_kind, last_token, line_width, open_levels
//
// A blank, or ordinary text outside an indentation run, leaves the controller idle.
// A line feed passes the newline state; a settle or end of input, the settle compare:
// an indent, no token, or a dedent walk of one pop per token, plus an indent and an error
// token on an indentation error. The output register takes one token per cycle unless
// stalled; the stack has a single read port. Reset opens one level of width 0; the stack
// needs no clearing. A stalled output holds the controller; bytes are taken only when idle.
module indent_dedent_token_scanner (
  input  logic         clk_i,
  input  logic         rst_ni,
  idts_byte_if.sink    byte_i,
  idts_token_if.source token_o
);
  import idts_pkg::*;

  cmd_t    cmd;
  status_t status;

  idts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .in_ready_o (byte_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  idts_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .text_byte_i   (byte_i.text_byte),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (token_o.valid),
    .out_ready_i   (token_o.ready),
    .token_kind_o  (token_o.token_kind),
    .last_token_o  (token_o.last_token),
    .line_width_o  (token_o.line_width),
    .open_levels_o (token_o.open_levels)
  );

endmodule

FILE: rtl/idts_ctrl.sv
// Controller of the layout token scanner: sequences byte intake, the
// settle compare, the dedent walk and token emission. Depends on idts_pkg.
module idts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  idts_pkg::status_t status_i,
  output idts_pkg::cmd_t    cmd_o
);
  import idts_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_NL     = 6'b000010,
    S_SETTLE = 6'b000100,
    S_WALK   = 6'b001000,
    S_INDERR = 6'b010000,
    S_ERR    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

  // Next state and command decode.
  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          case (status_i.cls) inside
            CLS_EOF, CLS_SETTLE: state_d = S_SETTLE;
            CLS_LF:              state_d = S_NL;
            default:             state_d = S_IDLE;
          endcase
        end
      end
      S_NL: begin
        if (status_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = TK_NEWLINE;
          cmd.last = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_SETTLE: begin
        if (status_i.w_gt_top) begin
          if (status_i.out_free) begin
            cmd.push = 1'b1;
            cmd.emit = 1'b1;
            cmd.kind = TK_INDENT;
            cmd.last = 1'b1;
            state_d  = S_IDLE;
          end
        end else if (status_i.w_eq_top) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        // One level popped per token; the entry below the top decides what follows.
        if (status_i.out_free) begin
          cmd.pop  = 1'b1;
          cmd.emit = 1'b1;
          cmd.kind = TK_DEDENT;
          cmd.last = status_i.w_eq_second;
          if (status_i.w_eq_second) begin
            state_d = S_IDLE;
          end else if (status_i.w_gt_second) begin
            state_d = S_INDERR;
          end
        end
      end
      S_INDERR: begin
        if (status_i.out_free) begin
          cmd.push = 1'b1;
          cmd.emit = 1'b1;
          cmd.kind = TK_INDENT;
          state_d  = S_ERR;
        end
      end
      S_ERR: begin
        if (status_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = TK_ERROR;
          cmd.last = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/idts_datapath.sv
// Datapath of the layout token scanner: width accumulator, level stack
// memory with cached top entry, and the output token register.
// Depends on idts_pkg.
module idts_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [idts_pkg::BYTE_W-1:0]   text_byte_i,
  input  idts_pkg::cmd_t                cmd_i,
  output idts_pkg::status_t             status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [idts_pkg::KIND_W-1:0]   token_kind_o,
  output logic                          last_token_o,
  output logic [idts_pkg::WIDTH_W-1:0]  line_width_o,
  output logic [idts_pkg::CNT_W-1:0]    open_levels_o
);
  import idts_pkg::*;

  // Indentation run state.
  logic               run_q, run_d;
  logic [WIDTH_W-1:0] acc_q, acc_d;
  logic [WIDTH_W-1:0] w_q, w_d;
  logic [WIDTH_W:0]   acc_sum;
  byte_cls_e          cls;

  // Level stack: entry 0 is the constant 0, entries above live in memory.
  logic [WIDTH_W-1:0] mem [STACK_DEPTH];
  logic [WIDTH_W-1:0] rd_q;
  logic [WIDTH_W-1:0] top_q, top_d;
  logic [WIDTH_W-1:0] second;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   cnt_m2;
  logic [PTR_W-1:0]   rd_addr;
  logic               full;
  logic               push_we;

  // Output token register.
  logic               out_valid_q;
  logic [KIND_W-1:0]  kind_q;
  logic               last_q;
  logic [WIDTH_W-1:0] lw_q;
  logic [CNT_W-1:0]   lvl_q;
  logic               out_free;

  // Byte classification.
  always_comb begin
    if (text_byte_i == CH_EOF) begin
      cls = CLS_EOF;
    end else if (text_byte_i == CH_LF) begin
      cls = CLS_LF;
    end else if (text_byte_i == CH_SP || text_byte_i == CH_TAB || text_byte_i == CH_CR) begin
      cls = CLS_BLANK;
    end else if (run_q) begin
      cls = CLS_SETTLE;
    end else begin
      cls = CLS_NONE;
    end
  end

  // Width step for a space or a tab, saturating at the field maximum.
  always_comb begin
    if (text_byte_i == CH_TAB) begin
      acc_sum = {1'b0, acc_q | WIDTH_W'(TAB_STOP - 1)} + (WIDTH_W + 1)'(1);
    end else begin
      acc_sum = {1'b0, acc_q} + (WIDTH_W + 1)'(1);
    end
  end

  // Run and width updates on an accepted byte.
  always_comb begin
    run_d = run_q;
    acc_d = acc_q;
    w_d   = w_q;
    if (cmd_i.accept) begin
      case (cls)
        CLS_EOF: begin
          run_d = 1'b0;
          acc_d = '0;
          w_d   = '0;
        end
        CLS_LF: begin
          run_d = 1'b1;
          acc_d = '0;
          w_d   = '0;
        end
        CLS_BLANK: begin
          if (run_q && text_byte_i != CH_CR) begin
            acc_d = acc_sum[WIDTH_W] ? '1 : acc_sum[WIDTH_W-1:0];
          end
        end
        CLS_SETTLE: begin
          run_d = 1'b0;
          acc_d = '0;
          w_d   = acc_q;
        end
        default: ;
      endcase
    end
  end

  // Stack pointer and cached top entry.
  assign full    = (cnt_q == CNT_W'(STACK_DEPTH));
  assign second  = (cnt_q == CNT_W'(2)) ? '0 : rd_q;
  assign push_we = cmd_i.push && !full;

  always_comb begin
    cnt_d = cnt_q;
    top_d = top_q;
    if (push_we) begin
      cnt_d = cnt_q + CNT_W'(1);
      top_d = w_q;
    end else if (cmd_i.pop) begin
      cnt_d = cnt_q - CNT_W'(1);
      top_d = second;
    end
  end

  // Prefetch the entry below the next top so it is ready when a pop comes.
  assign cnt_m2  = cnt_d - CNT_W'(2);
  assign rd_addr = cnt_m2[PTR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (push_we) begin
      mem[cnt_q[PTR_W-1:0]] <= w_q;
    end
    rd_q <= mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= CNT_W'(1);
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      run_q <= run_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      top_q <= top_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (cmd_i.emit) begin
      kind_q <= cmd_i.kind;
      last_q <= cmd_i.last;
      lw_q   <= w_q;
      lvl_q  <= cnt_d;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Status toward the controller.
  always_comb begin
    status_o.cls         = cls;
    status_o.out_free    = out_free;
    status_o.w_gt_top    = (w_q > top_q);
    status_o.w_eq_top    = (w_q == top_q);
    status_o.w_gt_second = (w_q > second);
    status_o.w_eq_second = (w_q == second);
  end

  assign out_valid_o   = out_valid_q;
  assign token_kind_o  = kind_q;
  assign last_token_o  = last_q;
  assign line_width_o  = lw_q;
  assign open_levels_o = lvl_q;

endmodule

FILE: rtl/idts_checker.sv
// Port-level checker of the layout token scanner, bound to the top level.
// Depends on idts_pkg and indent_dedent_token_scanner_defines.svh.
`include "indent_dedent_token_scanner_defines.svh"

module idts_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [idts_pkg::KIND_W-1:0]  token_kind_i,
  input logic                         last_token_i,
  input logic [idts_pkg::WIDTH_W-1:0] line_width_i,
  input logic [idts_pkg::CNT_W-1:0]   open_levels_i
);
  import idts_pkg::*;

  // A stalled token keeps its whole payload.
  `IDTS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(token_kind_i) && $stable(last_token_i) && $stable(line_width_i) && $stable(open_levels_i), "stalled token changed")

  // A newline is a single token of width zero.
  `IDTS_ASSERT_IMPL(a_nl_shape, clk_i, rst_ni, out_valid_i && token_kind_i == TK_NEWLINE, last_token_i && line_width_i == '0, "malformed newline token")

  // The tokens of one byte leave back to back.
  `IDTS_ASSERT_NEXT(a_burst, clk_i, rst_ni, out_valid_i && out_ready_i && !last_token_i, out_valid_i, "gap inside a token burst")

  // No new byte is taken while a burst is unfinished.
  `IDTS_ASSERT_IMPL(a_no_intake, clk_i, rst_ni, out_valid_i && !last_token_i, !in_ready_i, "byte taken during a token burst")

  // An indentation error always closes its burst.
  `IDTS_ASSERT_IMPL(a_err_last, clk_i, rst_ni, out_valid_i && token_kind_i == TK_ERROR, last_token_i, "error token not last")

endmodule

bind indent_dedent_token_scanner idts_checker u_idts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (byte_i.valid),
  .in_ready_i    (byte_i.ready),
  .out_valid_i   (token_o.valid),
  .out_ready_i   (token_o.ready),
  .token_kind_i  (token_o.token_kind),
  .last_token_i  (token_o.last_token),
  .line_width_i  (token_o.line_width),
  .open_levels_i (token_o.open_levels)
);

FILE: tb/indent_dedent_token_scanner_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the layout token scanner: a queue-fed byte driver,
// a token monitor and an in-bench model of the indentation stack.
// Depends on idts_pkg, idts_byte_if, idts_token_if and indent_dedent_token_scanner.
module indent_dedent_token_scanner_tb;
  import idts_pkg::*;

  localparam int WIDTH_SAT = 2**WIDTH_W - 1;

  typedef struct {
    token_kind_e        kind;
    logic               last;
    logic [WIDTH_W-1:0] width;
    logic [CNT_W-1:0]   levels;
  } layout_token_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  idts_byte_if  byte_bus ();
  idts_token_if token_bus ();

  indent_dedent_token_scanner dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_bus),
    .token_o (token_bus)
  );

  // Bytes waiting to be offered and tokens the scanner still owes us.
  logic [BYTE_W-1:0] text_q[$];
  layout_token_t     token_q[$];
  int                fail_count  = 0;
  int                tokens_seen = 0;

  // Shadow of the scanner state, advanced on every accepted byte request.
  logic               run_open;
  int                 run_width;
  logic [WIDTH_W-1:0] open_width[STACK_DEPTH];
  int                 open_cnt;

  // Driver and receiver pacing.
  int   burst_left;
  int   gap_left;
  int   hold_left;
  logic hold_done;
  int   window_left;
  int   stall_pct;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void emit_token(input token_kind_e kind, input int w);
    layout_token_t t;
    t.kind   = kind;
    t.last   = 1'b0;
    t.width  = WIDTH_W'(w);
    t.levels = CNT_W'(open_cnt);
    token_q.push_back(t);
  endfunction

  function automatic void push_level(input int w);
    if (open_cnt < STACK_DEPTH) begin
      open_width[open_cnt] = WIDTH_W'(w);
      open_cnt++;
    end
  endfunction

  // Work out the tokens one text byte causes and queue them in order.
  function automatic void predict_tokens(input logic [BYTE_W-1:0] b);
    int            before_cnt;
    int            w;
    layout_token_t t;
    before_cnt = token_q.size();
    if (b == CH_EOF) begin
      run_open  = 1'b0;
      run_width = 0;
      while (open_cnt > 1) begin
        open_cnt--;
        emit_token(TK_DEDENT, 0);
      end
    end else if (b == CH_LF) begin
      run_open  = 1'b1;
      run_width = 0;
      emit_token(TK_NEWLINE, 0);
    end else if (b == CH_SP || b == CH_TAB || b == CH_CR) begin
      if (run_open) begin
        if (b == CH_SP)
          run_width = run_width + 1;
        else if (b == CH_TAB)
          run_width = run_width + TAB_STOP - (run_width % TAB_STOP);
        if (run_width > WIDTH_SAT)
          run_width = WIDTH_SAT;
      end
    end else if (run_open) begin
      // The first other byte of a line settles its width against the stack.
      w         = run_width;
      run_open  = 1'b0;
      run_width = 0;
      if (w > int'(open_width[open_cnt-1])) begin
        push_level(w);
        emit_token(TK_INDENT, w);
      end else if (w < int'(open_width[open_cnt-1])) begin
        while (open_cnt > 1 && w < int'(open_width[open_cnt-1])) begin
          open_cnt--;
          emit_token(TK_DEDENT, w);
        end
        // Landing between two levels opens a new one and flags it.
        if (w > int'(open_width[open_cnt-1])) begin
          push_level(w);
          emit_token(TK_INDENT, w);
          emit_token(TK_ERROR, w);
        end
      end
    end
    if (token_q.size() > before_cnt) begin
      t      = token_q.pop_back();
      t.last = 1'b1;
      token_q.push_back(t);
    end
  endfunction

  // A byte that starts a line's text: never a blank, a line feed or end of input.
  function automatic logic [BYTE_W-1:0] text_char();
    logic [BYTE_W-1:0] c;
    c = BYTE_W'($urandom_range(1, 255));
    while (c == CH_LF || c == CH_SP || c == CH_TAB || c == CH_CR)
      c = BYTE_W'($urandom_range(1, 255));
    return c;
  endfunction

  // Leading blanks reaching width w from a random mix of spaces, tabs and CRs.
  function automatic void put_blanks(input int w);
    int pos;
    pos = 0;
    while (pos < w) begin
      if ($urandom_range(0, 5) == 0)
        text_q.push_back(CH_CR);
      if (pos - pos % TAB_STOP + TAB_STOP <= w && $urandom_range(0, 1) == 1) begin
        text_q.push_back(CH_TAB);
        pos = pos - pos % TAB_STOP + TAB_STOP;
      end else begin
        text_q.push_back(CH_SP);
        pos++;
      end
    end
  endfunction

  // One line: line feed, indentation of width w, then some text.
  function automatic void push_line(input int w);
    int                n;
    logic [BYTE_W-1:0] c;
    text_q.push_back(CH_LF);
    put_blanks(w);
    text_q.push_back(text_char());
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      c = BYTE_W'($urandom_range(1, 255));
      text_q.push_back((c == CH_LF) ? CH_SP : c);
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Byte driver: offers queued bytes in bursts separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_bus.valid     <= 1'b0;
      byte_bus.text_byte <= '0;
      burst_left         <= 0;
      gap_left           <= 0;
    end else begin
      if (byte_bus.valid && byte_bus.ready)
        predict_tokens(byte_bus.text_byte);
      if (!byte_bus.valid || byte_bus.ready) begin
        if (gap_left > 0 || text_q.size() == 0) begin
          byte_bus.valid <= 1'b0;
          if (gap_left > 0)
            gap_left <= gap_left - 1;
        end else begin
          byte_bus.valid     <= 1'b1;
          byte_bus.text_byte <= text_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Token receiver: stall rate changes per window, plus one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_bus.ready <= 1'b0;
      hold_left       <= 0;
      hold_done       <= 1'b0;
      window_left     <= 0;
      stall_pct       <= 0;
    end else begin
      if (!hold_done && tokens_seen >= 20) begin
        hold_left       <= 400;
        hold_done       <= 1'b1;
        token_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left       <= hold_left - 1;
        token_bus.ready <= 1'b0;
      end else begin
        token_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
      if (window_left == 0) begin
        window_left <= $urandom_range(16, 96);
        case ($urandom_range(0, 2))
          0: stall_pct <= 0;
          1: stall_pct <= 30;
          default: stall_pct <= 70;
        endcase
      end else begin
        window_left <= window_left - 1;
      end
    end
  end

  // Token monitor: each accepted token request against the oldest prediction.
  always @(posedge clk_i) begin
    layout_token_t want;
    if (rst_ni && token_bus.valid && token_bus.ready) begin
      tokens_seen <= tokens_seen + 1;
      if (token_q.size() == 0) begin
        $error("unexpected token: kind %0d, width %0d, levels %0d",
               token_bus.token_kind, token_bus.line_width, token_bus.open_levels);
        fail_count++;
      end else begin
        want = token_q.pop_front();
        check_field("token_kind", 32'(want.kind), 32'(token_bus.token_kind));
        check_field("last_token", 32'(want.last), 32'(token_bus.last_token));
        check_field("line_width", 32'(want.width), 32'(token_bus.line_width));
        check_field("open_levels", 32'(want.levels), 32'(token_bus.open_levels));
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int depth;
    int pick;
    int r;
    int w;
    int rand_start;
    byte_bus.valid     = 1'b0;
    byte_bus.text_byte = '0;
    token_bus.ready    = 1'b0;
    run_open           = 1'b0;
    run_width          = 0;
    open_cnt           = 1;
    foreach (open_width[i])
      open_width[i] = '0;

    // Blanks and text before the first line feed are not measured.
    text_q.push_back(CH_SP);
    text_q.push_back(CH_TAB);
    text_q.push_back(CH_CR);
    text_q.push_back(8'hFF);
    // Indent twice, keep the width, then a blank line and an exact dedent.
    push_line(2);
    push_line(8);
    push_line(8);
    text_q.push_back(CH_LF);
    push_line(2);
    // Width between two levels, then back to the bottom.
    push_line(1);
    push_line(0);
    // End of input with nothing open, then with one level, then again.
    text_q.push_back(CH_EOF);
    push_line(3);
    text_q.push_back(CH_EOF);
    text_q.push_back(CH_EOF);
    // End of input inside an indentation run closes the run.
    text_q.push_back(CH_LF);
    text_q.push_back(CH_SP);
    text_q.push_back(CH_EOF);
    text_q.push_back(CH_SP);
    text_q.push_back(8'h80);
    // Three nested levels, then a dedent walk that lands between the bottom level and the first of them.
    for (int k = 1; k <= 3; k++)
      push_line(8 * k);
    push_line(4);
    text_q.push_back(CH_EOF);

    // Random part: mostly well-formed nested lines, some noise, ends of input and blank lines.
    rand_start = text_q.size();
    depth      = 0;
    while (text_q.size() < rand_start + 60) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        text_q.push_back(BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 12) begin
        text_q.push_back(CH_EOF);
        depth = 0;
      end else if (pick < 18) begin
        text_q.push_back(CH_LF);
        put_blanks($urandom_range(0, 12));
      end else begin
        r = $urandom_range(0, 9);
        if (r < 4 && depth < 12)
          depth++;
        else if (r < 8)
          depth = $urandom_range(0, depth);
        w = 4 * depth + ((r == 9) ? 2 : 0);
        push_line(w);
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every byte request to be taken and every token to arrive.
    while (text_q.size() != 0 || byte_bus.valid)
      @(negedge clk_i);
    while (token_q.size() != 0)
      @(negedge clk_i);
    repeat (100) @(negedge clk_i);

    if (token_q.size() != 0) begin
      $error("%0d predicted tokens never arrived", token_q.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("PASS indent_dedent_token_scanner");
    else
      $display("FAIL indent_dedent_token_scanner");
    $finish;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("FAIL indent_dedent_token_scanner");
    $finish;
  end

endmodule
